>>> sv/lmb_pkg.sv
// ----------------------------------------------------------------------------
// lmb_pkg
// Shared types and constants of the LCD micro-bar glyph builder.
// ----------------------------------------------------------------------------
`default_nettype none

package lmb_pkg;

	localparam int SLOTS_DEF    = 8;
	localparam int SLOT_FW      = 3;
	localparam int CMD_W        = 2;
	localparam int HEIGHT_W     = 8;
	localparam int ROWS         = 8;
	localparam int ROW_W        = 5;
	localparam int GLYPH_W      = ROWS * ROW_W;
	localparam int MAX_HEIGHT   = 8;
	localparam int CLAMP_W      = 4;
	localparam int CURSOR_LIMIT = 24;
	localparam int BAR_IDX_W    = 5;

	localparam logic [ROW_W-1:0] LEFT_MASK   = 5'b10000;
	localparam logic [ROW_W-1:0] CENTER_MASK = 5'b00100;
	localparam logic [ROW_W-1:0] RIGHT_MASK  = 5'b00001;

	typedef enum logic [CMD_W-1:0] {
		CMD_DRAW  = 2'd0,
		CMD_INVAL = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_t;

	// Request from the control path to the glyph cache
	typedef struct packed {
		logic               draw;
		logic               inval;
		logic               clr;
		logic [SLOT_FW-1:0] idx;
	} cache_req_t;

endpackage

`default_nettype wire

>>> sv/lmb_glyph.sv
// ----------------------------------------------------------------------------
// lmb_glyph
// Builds one 5x8 glyph from three bar heights and the cursor marker.
// ----------------------------------------------------------------------------
`default_nettype none

module lmb_glyph (
	input  wire logic [lmb_pkg::SLOT_FW-1:0]  slot,
	input  wire logic [lmb_pkg::HEIGHT_W-1:0] left_height,
	input  wire logic [lmb_pkg::HEIGHT_W-1:0] center_height,
	input  wire logic [lmb_pkg::HEIGHT_W-1:0] right_height,
	input  wire logic [lmb_pkg::HEIGHT_W-1:0] marker,
	output logic      [lmb_pkg::GLYPH_W-1:0]  glyph
);
	import lmb_pkg::*;

	logic [CLAMP_W-1:0]   lh, ch, rh;
	logic [BAR_IDX_W-1:0] base;
	logic [BAR_IDX_W-1:0] mk;
	logic [ROW_W-1:0]     cursor;

	function automatic logic [CLAMP_W-1:0] clamp(input logic [HEIGHT_W-1:0] h);
		if (h > HEIGHT_W'(MAX_HEIGHT))
			return CLAMP_W'(MAX_HEIGHT);
		return h[CLAMP_W-1:0];
	endfunction

	assign lh = clamp(left_height);
	assign ch = clamp(center_height);
	assign rh = clamp(right_height);

	// first bar index of this slot: slot * 3
	assign base = BAR_IDX_W'({slot, 1'b0}) + BAR_IDX_W'(slot);
	assign mk   = marker[BAR_IDX_W-1:0];

	always_comb begin
		cursor = '0;
		if (marker < HEIGHT_W'(CURSOR_LIMIT)) begin
			if (mk == base)
				cursor = LEFT_MASK;
			else if (mk == base + BAR_IDX_W'(1))
				cursor = CENTER_MASK;
			else if (mk == base + BAR_IDX_W'(2))
				cursor = RIGHT_MASK;
		end
	end

	// bar h fills the bottom h rows; row 7 is the bottom
	always_comb begin
		logic [ROW_W-1:0] v;
		for (int r = 0; r < ROWS; r++) begin
			v = '0;
			if (lh >= CLAMP_W'(ROWS - r))
				v = v | LEFT_MASK;
			if (ch >= CLAMP_W'(ROWS - r))
				v = v | CENTER_MASK;
			if (rh >= CLAMP_W'(ROWS - r))
				v = v | RIGHT_MASK;
			if ((r % 2) == 0)
				v = v ^ cursor;
			glyph[r*ROW_W +: ROW_W] = v;
		end
	end

endmodule

`default_nettype wire

>>> sv/lmb_cache.sv
// ----------------------------------------------------------------------------
// lmb_cache
// Per-slot glyph cache with valid bits; flags a hit, stores the glyph on a draw miss, zeroes a slot on clear
// and drops all valid bits on invalidate.
`default_nettype none

module lmb_cache #(
	parameter int SLOTS = lmb_pkg::SLOTS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire lmb_pkg::cache_req_t        req,
	input  wire logic [lmb_pkg::GLYPH_W-1:0] glyph,
	output logic                            hit
);
	import lmb_pkg::*;

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	logic [GLYPH_W-1:0] glyph_q [SLOTS];
	logic [SLOTS-1:0]   valid_q;
	logic [IDX_W-1:0]   idx;

	assign idx = req.idx[IDX_W-1:0];
	assign hit = valid_q[idx] && (glyph_q[idx] == glyph);

	always_ff @(posedge clk) begin
		if (req.clr)
			glyph_q[idx] <= '0;
		else if (req.draw && !hit)
			glyph_q[idx] <= glyph;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.inval) begin
			valid_q <= '0;
		end else if (req.clr || (req.draw && !hit)) begin
			valid_q[idx] <= 1'b1;
		end
	end

endmodule

`default_nettype wire

>>> sv/lcd_microbar_glyph_builder.sv
// ----------------------------------------------------------------------------
// lcd_microbar_glyph_builder
// Custom-character glyph builder for a character LCD bar graph, with a
// per-slot cache so that a draw sends only a changed glyph.
// ----------------------------------------------------------------------------
//  channel   | handshake            | payload
//  ----------+----------------------+------------------------------------------
//  command   | start / busy         | cmd, slot, *_height, marker
//  result    | strobe (one cycle)   | char_slot, glyph_rows, last
//
//  A draw or invalidate item is taken every cycle while busy is low; its result,
//  if any, passes the input register, then the result register.
//  A clear item holds busy high until its final slot while a counter walks the
//  slots, giving one result per cycle, slot 0 first.
//  Reset clears the pipeline valid, the sweep counter and all valid bits.
//  The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_microbar_glyph_builder #(
	parameter int SLOTS = lmb_pkg::SLOTS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [lmb_pkg::CMD_W-1:0]    cmd,
	input  wire logic [lmb_pkg::SLOT_FW-1:0]  slot,
	input  wire logic [lmb_pkg::HEIGHT_W-1:0] left_height,
	input  wire logic [lmb_pkg::HEIGHT_W-1:0] center_height,
	input  wire logic [lmb_pkg::HEIGHT_W-1:0] right_height,
	input  wire logic [lmb_pkg::HEIGHT_W-1:0] marker,
	output logic                              strobe,
	output logic      [lmb_pkg::SLOT_FW-1:0]  char_slot,
	output logic      [lmb_pkg::GLYPH_W-1:0]  glyph_rows,
	output logic                              last
);
	import lmb_pkg::*;

	localparam int CNT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [SLOT_FW:0] SLOTS_L = (SLOT_FW + 1)'(SLOTS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SLOTS - 1);

	logic                 accept;
	logic                 vld_s1;
	logic [CMD_W-1:0]     cmd_s1;
	logic [SLOT_FW-1:0]   slot_s1;
	logic [HEIGHT_W-1:0]  lh_s1, ch_s1, rh_s1, marker_s1;
	logic [CNT_W-1:0]     cnt_q;

	logic                 draw_ok, clear_act, sweep_last, hit;
	logic [GLYPH_W-1:0]   glyph;
	cache_req_t           req;

	logic                 strobe_q, last_q;
	logic [SLOT_FW-1:0]   char_slot_q;
	logic [GLYPH_W-1:0]   glyph_q;

	assign clear_act  = vld_s1 && (cmd_s1 == CMD_CLEAR);
	assign sweep_last = (cnt_q == CNT_LAST);
	assign busy       = clear_act && !sweep_last;
	assign accept     = start && !busy;
	assign draw_ok    = vld_s1 && (cmd_s1 == CMD_DRAW) && ({1'b0, slot_s1} < SLOTS_L);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (!busy) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1    <= cmd;
			slot_s1   <= slot;
			lh_s1     <= left_height;
			ch_s1     <= center_height;
			rh_s1     <= right_height;
			marker_s1 <= marker;
		end
	end

	// advance the clear sweep, wrap on the final slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (clear_act) begin
			cnt_q <= sweep_last ? '0 : cnt_q + CNT_W'(1);
		end
	end

	lmb_glyph u_glyph (
		.slot          (slot_s1),
		.left_height   (lh_s1),
		.center_height (ch_s1),
		.right_height  (rh_s1),
		.marker        (marker_s1),
		.glyph         (glyph)
	);

	always_comb begin
		req.draw  = draw_ok;
		req.inval = vld_s1 && (cmd_s1 == CMD_INVAL);
		req.clr   = clear_act;
		req.idx   = clear_act ? SLOT_FW'(cnt_q) : slot_s1;
	end

	lmb_cache #(
		.SLOTS (SLOTS)
	) u_cache (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.glyph  (glyph),
		.hit    (hit)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (draw_ok && !hit) || clear_act;
		end
	end

	always_ff @(posedge clk) begin
		char_slot_q <= req.idx;
		glyph_q     <= clear_act ? '0 : glyph;
		last_q      <= clear_act ? sweep_last : 1'b1;
	end

	assign strobe     = strobe_q;
	assign char_slot  = char_slot_q;
	assign glyph_rows = glyph_q;
	assign last       = last_q;

endmodule

`default_nettype wire

>>> sv/lmb_checker.sv
// ----------------------------------------------------------------------------
// lmb_checker
// Port-level checks of the glyph builder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lmb_checker #(
	parameter int SLOTS = lmb_pkg::SLOTS_DEF
) (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         start,
	input wire logic                         busy,
	input wire logic [lmb_pkg::CMD_W-1:0]    cmd,
	input wire logic                         strobe,
	input wire logic [lmb_pkg::SLOT_FW-1:0]  char_slot,
	input wire logic                         last
);
	import lmb_pkg::*;

	// no result strobe in the cycle after arst_n is sampled low
	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !strobe)
		else $error("result strobe during reset");

	// clear sweep: results run slot by slot without a gap
	a_sweep_next: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe && (char_slot == $past(char_slot) + SLOT_FW'(1)))
		else $error("clear sweep broke its slot sequence");

	// a non-final result only comes from a sweep that held busy
	a_sweep_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> $past(busy))
		else $error("non-final result without busy");

	// an accepted clear raises busy when there is more than one slot
	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(SLOTS > 1) && start && !busy && (cmd == CMD_CLEAR) |=> busy)
		else $error("clear accepted without busy");

endmodule

bind lcd_microbar_glyph_builder lmb_checker #(
	.SLOTS (SLOTS)
) u_lmb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.cmd       (cmd),
	.strobe    (strobe),
	.char_slot (char_slot),
	.last      (last)
);

`default_nettype wire
